// ----- design/aolt_pkg.sv -----
// Shared types, constants and the microcode program of the A* open list table.
// No dependencies; aolt_sequencer, aolt_datapath and the top level use it.

package aolt_pkg;

  // Table geometry
  localparam int NODE_CAPACITY = 512;
  localparam int ADDR_W        = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
  localparam int COUNT_W       = $clog2(NODE_CAPACITY + 1);

  // Field widths
  localparam int OP_W      = 3;
  localparam int INDEX_W   = 9;
  localparam int POS_W     = 16;
  localparam int COST_W    = 24;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 10;

  localparam logic [COST_W-1:0] CEILING_RESET = 24'd100000;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_BEST   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd2;
  localparam logic [OP_W-1:0] OP_OPEN   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] node_index;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COST_W-1:0]  cost;
  } request_t;

  // One word of the entry memory
  typedef struct packed {
    logic              mark;
    logic [COST_W-1:0] cost;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } entry_t;

  // Datapath actions selected by a control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CREATE,
    ACT_SCAN_INIT,
    ACT_SCAN_STEP,
    ACT_SCAN_EVAL,
    ACT_SCAN_DONE,
    ACT_MARK_READ,
    ACT_MARK_WRITE,
    ACT_CLEAR
  } act_t;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_EMPTY,
    COND_MORE
  } cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Program addresses
  localparam upc_t U_CREATE     = 4'd0;
  localparam upc_t U_SEARCH     = 4'd1;
  localparam upc_t U_SCAN       = 4'd2;
  localparam upc_t U_DRAIN      = 4'd3;
  localparam upc_t U_SEARCH_END = 4'd4;
  localparam upc_t U_MARK       = 4'd5;
  localparam upc_t U_MARK_WR    = 4'd6;
  localparam upc_t U_CLEAR      = 4'd7;
  localparam upc_t U_NOP        = 4'd8;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  done;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    act_t act;
    logic fire;
    logic done;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic empty;
    logic more;
    logic out_busy;
  } flags_t;

  // Microcode store
  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    w.act    = ACT_NONE;
    w.cond   = COND_NEVER;
    w.target = U_CREATE;
    w.done   = 1'b1;
    unique case (addr)
      U_CREATE: begin
        w.act = ACT_CREATE;
      end
      U_SEARCH: begin
        w.act    = ACT_SCAN_INIT;
        w.cond   = COND_EMPTY;
        w.target = U_SEARCH_END;
        w.done   = 1'b0;
      end
      U_SCAN: begin
        w.act    = ACT_SCAN_STEP;
        w.cond   = COND_MORE;
        w.target = U_SCAN;
        w.done   = 1'b0;
      end
      U_DRAIN: begin
        w.act  = ACT_SCAN_EVAL;
        w.done = 1'b0;
      end
      U_SEARCH_END: begin
        w.act = ACT_SCAN_DONE;
      end
      U_MARK: begin
        w.act  = ACT_MARK_READ;
        w.done = 1'b0;
      end
      U_MARK_WR: begin
        w.act = ACT_MARK_WRITE;
      end
      U_CLEAR: begin
        w.act = ACT_CLEAR;
      end
      default: begin
        w.act = ACT_NONE;
      end
    endcase
    return w;
  endfunction

  // Program start for each operation
  function automatic upc_t entry_point(input logic [OP_W-1:0] op);
    upc_t a;
    unique case (op)
      OP_CREATE: a = U_CREATE;
      OP_BEST:   a = U_SEARCH;
      OP_FIND:   a = U_SEARCH;
      OP_CLOSE:  a = U_MARK;
      OP_OPEN:   a = U_MARK;
      OP_CLEAR:  a = U_CLEAR;
      default:   a = U_NOP;
    endcase
    return a;
  endfunction

endpackage

// ----- design/aolt_sequencer.sv -----
// Microcode sequencer: step counter, program fetch and conditional jumps.
// Depends on aolt_pkg.

module aolt_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_accept,
  input  logic [aolt_pkg::OP_W-1:0] in_op,
  input  aolt_pkg::flags_t          flags,
  output logic                      in_ready,
  output aolt_pkg::ctrl_t           ctrl
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state;
  aolt_pkg::upc_t   upc;
  aolt_pkg::ucode_t word;
  logic             stall;
  logic             taken;

  // Fetch and branch decision
  always_comb begin
    word  = aolt_pkg::ucode_rom(upc);
    stall = word.done && flags.out_busy;
    unique case (word.cond)
      aolt_pkg::COND_EMPTY: taken = flags.empty;
      aolt_pkg::COND_MORE:  taken = flags.more;
      default:              taken = 1'b0;
    endcase
  end

  assign in_ready  = (state == SEQ_IDLE) && !rst;
  assign ctrl.act  = word.act;
  assign ctrl.done = word.done;
  assign ctrl.fire = (state == SEQ_RUN) && !stall;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= aolt_pkg::U_NOP;
    end else begin
      unique case (state)
        SEQ_IDLE: begin
          if (in_accept) begin
            upc   <= aolt_pkg::entry_point(in_op);
            state <= SEQ_RUN;
          end
        end
        SEQ_RUN: begin
          if (!stall) begin
            if (word.done) begin
              state <= SEQ_IDLE;
            end else if (taken) begin
              upc <= word.target;
            end else begin
              upc <= upc + 1'b1;
            end
          end
        end
        default: state <= SEQ_IDLE;
      endcase
    end
  end

endmodule

// ----- design/aolt_datapath.sv -----
// Datapath: entry memory, scan registers, counters, ceiling and result register.
// Depends on aolt_pkg; driven by aolt_sequencer control words.

module aolt_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_accept,
  input  aolt_pkg::request_t             req,
  input  logic                           cfg_valid,
  input  logic [aolt_pkg::COST_W-1:0]    cfg_data,
  input  aolt_pkg::ctrl_t                ctrl,
  input  logic                           out_ready,
  output aolt_pkg::flags_t               flags,
  output logic                           out_valid,
  output logic [aolt_pkg::STATUS_W-1:0]  out_status,
  output logic [aolt_pkg::INDEX_W-1:0]   out_index,
  output logic [aolt_pkg::CNT_OUT_W-1:0] out_live,
  output logic [aolt_pkg::CNT_OUT_W-1:0] out_open,
  output logic [aolt_pkg::CNT_OUT_W-1:0] out_closed
);

  localparam int CMP_W = aolt_pkg::COUNT_W + 1;

  aolt_pkg::entry_t entry_mem [aolt_pkg::NODE_CAPACITY];
  aolt_pkg::entry_t rd_word;

  aolt_pkg::request_t            cur;
  logic [aolt_pkg::COST_W-1:0]   ceiling;
  aolt_pkg::count_t              used;
  aolt_pkg::count_t              open_total;
  aolt_pkg::count_t              scan_idx;
  aolt_pkg::addr_t               pend_idx;
  logic                          pend_valid;
  logic [aolt_pkg::COST_W-1:0]   best_cost;
  aolt_pkg::addr_t               best_idx;
  logic                          found;

  aolt_pkg::count_t              used_next;
  aolt_pkg::count_t              open_next;
  aolt_pkg::count_t              closed_next;
  aolt_pkg::addr_t               mem_addr;
  logic                          mem_we;
  aolt_pkg::entry_t              mem_wdata;
  logic [aolt_pkg::STATUS_W-1:0] res_status;
  aolt_pkg::addr_t               res_index;
  aolt_pkg::addr_t               node_addr;
  logic                          node_in_range;
  logic                          node_live;
  logic                          full;
  logic                          mark_new;
  logic                          hit;
  logic                          scan_act;

  assign node_addr     = aolt_pkg::addr_t'(cur.node_index);
  assign node_in_range = 32'(cur.node_index) < 32'(aolt_pkg::NODE_CAPACITY);
  assign node_live     = 32'(cur.node_index) < 32'(used);
  assign full          = (used == aolt_pkg::count_t'(aolt_pkg::NODE_CAPACITY));
  assign mark_new      = (cur.op == aolt_pkg::OP_OPEN);

  // Candidate test on the word read in the previous step
  always_comb begin
    if (cur.op == aolt_pkg::OP_BEST) begin
      hit = pend_valid && rd_word.mark && (rd_word.cost < best_cost);
    end else begin
      hit = pend_valid && !found && (rd_word.pos_x == cur.pos_x) &&
            (rd_word.pos_y == cur.pos_y);
    end
  end

  assign scan_act = (ctrl.act == aolt_pkg::ACT_SCAN_STEP) ||
                    (ctrl.act == aolt_pkg::ACT_SCAN_EVAL);

  // Memory port, counter updates and result
  always_comb begin
    mem_addr   = scan_idx[aolt_pkg::ADDR_W-1:0];
    mem_we     = 1'b0;
    mem_wdata  = rd_word;
    used_next  = used;
    open_next  = open_total;
    res_status = aolt_pkg::ST_OK;
    res_index  = '0;
    unique case (ctrl.act)
      aolt_pkg::ACT_CREATE: begin
        mem_addr = used[aolt_pkg::ADDR_W-1:0];
        if (full) begin
          res_status = aolt_pkg::ST_FULL;
        end else begin
          mem_we          = ctrl.fire;
          mem_wdata.mark  = 1'b1;
          mem_wdata.cost  = cur.cost;
          mem_wdata.pos_y = cur.pos_y;
          mem_wdata.pos_x = cur.pos_x;
          res_index       = used[aolt_pkg::ADDR_W-1:0];
          used_next       = used + 1'b1;
          open_next       = open_total + 1'b1;
        end
      end
      aolt_pkg::ACT_MARK_READ: begin
        mem_addr = node_addr;
      end
      aolt_pkg::ACT_MARK_WRITE: begin
        mem_addr       = node_addr;
        mem_wdata.mark = mark_new;
        if (node_in_range) begin
          mem_we = ctrl.fire;
          if (node_live && (rd_word.mark != mark_new)) begin
            open_next = mark_new ? open_total + 1'b1 : open_total - 1'b1;
          end
        end
      end
      aolt_pkg::ACT_SCAN_DONE: begin
        if (found) begin
          res_index = best_idx;
        end else begin
          res_status = aolt_pkg::ST_NONE;
        end
      end
      aolt_pkg::ACT_CLEAR: begin
        used_next = '0;
        open_next = '0;
      end
      default: ;
    endcase
    closed_next = used_next - open_next;
  end

  assign flags.empty    = (used == '0);
  assign flags.more     = (CMP_W'(scan_idx) + 1'b1) < CMP_W'(used);
  assign flags.out_busy = out_valid && !out_ready;

  // Entry memory, single port with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_addr] <= mem_wdata;
    end
    rd_word <= entry_mem[mem_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur <= req;
    end
    if (ctrl.fire) begin
      if (ctrl.act == aolt_pkg::ACT_SCAN_INIT) begin
        best_cost <= ceiling;
      end
      if (ctrl.act == aolt_pkg::ACT_SCAN_STEP) begin
        pend_idx <= scan_idx[aolt_pkg::ADDR_W-1:0];
      end
      if (scan_act && hit) begin
        best_cost <= rd_word.cost;
        best_idx  <= pend_idx;
      end
      if (ctrl.done) begin
        out_status <= res_status;
        out_index  <= aolt_pkg::INDEX_W'(res_index);
        out_live   <= aolt_pkg::CNT_OUT_W'(used_next);
        out_open   <= aolt_pkg::CNT_OUT_W'(open_next);
        out_closed <= aolt_pkg::CNT_OUT_W'(closed_next);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling    <= aolt_pkg::CEILING_RESET;
      used       <= '0;
      open_total <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ceiling <= cfg_data;
      end
      if (ctrl.fire) begin
        used       <= used_next;
        open_total <= open_next;
        unique case (ctrl.act)
          aolt_pkg::ACT_SCAN_INIT: begin
            scan_idx   <= '0;
            pend_valid <= 1'b0;
            found      <= 1'b0;
          end
          aolt_pkg::ACT_SCAN_STEP: begin
            scan_idx   <= scan_idx + 1'b1;
            pend_valid <= 1'b1;
          end
          aolt_pkg::ACT_SCAN_EVAL: begin
            pend_valid <= 1'b0;
          end
          default: ;
        endcase
        if (scan_act && hit) begin
          found <= 1'b1;
        end
      end
      // Result register
      if (ctrl.fire && ctrl.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/astar_open_list_table.sv -----
// Top level of the A* open list table: stream ports, sequencer and datapath.
// Depends on aolt_pkg, aolt_sequencer and aolt_datapath.

// The table holds up to aolt_pkg::NODE_CAPACITY entries (512) in one single-port
// memory, run by a small microcode program per operation. One item is taken at
// a time; its result lands in an output register, so the next item is accepted
// while that result waits. Create, clear and unused operations run a single control
// word; close and open read the entry, then write its mark. Best and find walk the
// live entries through the memory port one entry per cycle, then check the last
// word read; on an empty table they skip the walk. The entry memory is not cleared
// after reset; the block is ready once reset is low. The cost ceiling is written
// through the cfg channel, which is ready whenever reset is low.

module astar_open_list_table (
  input  logic        clk,
  input  logic        rst,
  // Configuration: cost ceiling
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // node_index[8:0], pos_x[24:9], pos_y[40:25], cost[64:41]
  input  logic [2:0]  s_axis_tuser,  // operation[2:0]
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // result_index[8:0], live[18:9], open[28:19], closed[38:29]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  aolt_pkg::request_t            req;
  aolt_pkg::ctrl_t               ctrl;
  aolt_pkg::flags_t              flags;
  logic                          in_accept;
  logic [aolt_pkg::INDEX_W-1:0]  out_index;
  logic [aolt_pkg::CNT_OUT_W-1:0] out_live;
  logic [aolt_pkg::CNT_OUT_W-1:0] out_open;
  logic [aolt_pkg::CNT_OUT_W-1:0] out_closed;

  // Unpack request
  assign req.op         = s_axis_tuser;
  assign req.node_index = s_axis_tdata[8:0];
  assign req.pos_x      = s_axis_tdata[24:9];
  assign req.pos_y      = s_axis_tdata[40:25];
  assign req.cost       = s_axis_tdata[64:41];

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = !rst;

  aolt_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_op     (s_axis_tuser),
    .flags     (flags),
    .in_ready  (s_axis_tready),
    .ctrl      (ctrl)
  );

  aolt_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .req        (req),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .ctrl       (ctrl),
    .out_ready  (m_axis_tready),
    .flags      (flags),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_index  (out_index),
    .out_live   (out_live),
    .out_open   (out_open),
    .out_closed (out_closed)
  );

  // Pack result
  assign m_axis_tdata = {1'b0, out_closed, out_open, out_live, out_index};

endmodule
